/* src/collatz_pkg.sv */
// ----------------------------------------------------------------------------
// collatz_pkg
// Shared beat types and default sizes for the chained Collatz step counter.
// ----------------------------------------------------------------------------
package collatz_pkg;

	// Default step limit and working value width
	localparam int MAX_STEPS_DEF   = 255;
	localparam int VALUE_WIDTH_DEF = 20;

	// Input beat: one character code
	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} in_beat_t;

	// Output beat: one step count
	typedef struct packed {
		logic [7:0] step_count;
		logic       bad_seed;
		logic       last_out;
	} out_beat_t;

endpackage

/* src/collatz_step_unit.sv */
// ----------------------------------------------------------------------------
// collatz_step_unit
// Shared arithmetic unit: one Collatz step on the working value, with an
// overflow flag for the 3v+1 branch.
// ----------------------------------------------------------------------------
module collatz_step_unit import collatz_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic [VALUE_WIDTH-1:0] value,
	output logic [VALUE_WIDTH-1:0] next_value,
	output logic                   overflow
);

	logic                   odd;
	logic [VALUE_WIDTH+1:0] triple;

	// Form 3v+1 with two guard bits
	assign odd    = value[0];
	assign triple = {2'b00, value} + {1'b0, value, 1'b0} + (VALUE_WIDTH+2)'(1);

	// Pick halve or 3v+1; flag any carry past the value width
	assign next_value = odd ? triple[VALUE_WIDTH-1:0] : {1'b0, value[VALUE_WIDTH-1:1]};
	assign overflow   = odd && (triple[VALUE_WIDTH+1:VALUE_WIDTH] != 2'b00);

endmodule

/* src/chained_collatz_step_counter.sv */
// ----------------------------------------------------------------------------
// chained_collatz_step_counter
// Counts Collatz steps from (char_code + chain offset) down to 1, one item
// at a time, and chains each count into the next item's seed.
// ----------------------------------------------------------------------------
// Each item is handled in order: take the beat and form the seed, walk
// the Collatz steps through the single shared step unit, then decide and
// load the result register. A zero seed, an overflow of the
// VALUE_WIDTH-bit working value or MAX_STEPS steps without reaching 1
// stops the walk early with a count of min(MAX_STEPS, 255) and bad_seed
// set. item_stall is high while an item is in the walk; a finished beat
// waits in the result register and the walk's last cycle holds until that
// register is free. The chain offset is the last emitted count and clears
// after a beat with last_char set.
module chained_collatz_step_counter import collatz_pkg::*; #(
	parameter int MAX_STEPS   = MAX_STEPS_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_beat_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_beat_t result
);

	localparam int         CNT_W = $clog2(MAX_STEPS + 1);
	localparam logic [7:0] SAT   = 8'((MAX_STEPS > 255) ? 255 : MAX_STEPS);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                   state_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   last_q;
	logic [7:0]             offset_q;
	logic                   out_valid_q;
	out_beat_t              out_q;

	logic                   take;
	logic                   out_free;
	logic [8:0]             seed;
	logic [VALUE_WIDTH-1:0] next_value;
	logic                   overflow;
	logic [CNT_W+7:0]       cnt_ext;
	logic                   finish;
	logic [7:0]             fin_count;
	logic                   fin_flag;

	collatz_step_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_step (
		.value     (value_q),
		.next_value(next_value),
		.overflow  (overflow)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign take         = item_valid && !item_stall;
	assign out_free     = !out_valid_q || !result_stall;
	assign seed         = {1'b0, item.char_code} + {1'b0, offset_q};
	assign cnt_ext      = {8'b0, cnt_q};
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Decide whether the walk ends this cycle and with what count
	always_comb begin
		finish    = 1'b0;
		fin_count = SAT;
		fin_flag  = 1'b1;
		if (value_q == '0) begin
			finish = 1'b1;
		end else if (value_q == VALUE_WIDTH'(1)) begin
			finish = 1'b1;
			if ((cnt_ext >> 8) == '0) begin
				fin_count = cnt_ext[7:0];
				fin_flag  = 1'b0;
			end else begin
				fin_count = 8'hff;
			end
		end else if (cnt_q >= CNT_W'(MAX_STEPS)) begin
			finish = 1'b1;
		end else if (overflow) begin
			finish = 1'b1;
		end
	end

	// Sequencer: load the seed, step until done, hand the beat to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			offset_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (finish && out_free) begin
						state_q  <= ST_IDLE;
						offset_q <= last_q ? 8'h00 : fin_count;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working value and step count
	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= VALUE_WIDTH'(seed);
			cnt_q   <= '0;
			last_q  <= item.last_char;
		end else if (state_q == ST_RUN && !finish) begin
			value_q <= next_value;
			cnt_q   <= cnt_q + CNT_W'(1);
		end
	end

	// Result register: load on finish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RUN && finish && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && finish && out_free) begin
			out_q.step_count <= fin_count;
			out_q.bad_seed   <= fin_flag;
			out_q.last_out   <= last_q;
		end
	end

endmodule
